### hdl/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared sizes, register indexes and gain limits for the spectral peak picker.
// ----------------------------------------------------------------------------
package spp_pkg;

   localparam int NUM_BINS  = 128;
   localparam int MAX_PEAKS = 16;
   localparam int MAG_WIDTH = 24;

   localparam int BIN_W    = $clog2(NUM_BINS);
   localparam int CNT_W    = BIN_W + 1;
   localparam int PK_IDX_W = $clog2(MAX_PEAKS);
   localparam int PK_CNT_W = PK_IDX_W + 1;
   localparam int GAIN_W   = 16;
   localparam int COEF_W   = 17;
   localparam int PROD_W   = MAG_WIDTH + COEF_W;
   localparam int LEVEL_W  = 16;
   localparam int QUOT_W   = 27;
   localparam int DCNT_W   = $clog2(QUOT_W + 1);

   // configuration register indexes
   localparam logic [1:0] CSR_NPEAKS      = 2'd0;
   localparam logic [1:0] CSR_MIN_SPACING = 2'd1;
   localparam logic [1:0] CSR_ALPHA       = 2'd2;

   localparam logic [GAIN_W-1:0]  GAIN_MIN  = 16'd410;
   localparam logic [GAIN_W-1:0]  GAIN_MAX  = 16'd40960;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'd32768;

   typedef logic [BIN_W-1:0]     bin_type;
   typedef logic [MAG_WIDTH-1:0] mag_type;

endpackage

### hdl/spp_bin_ram.sv
// ----------------------------------------------------------------------------
// spp_bin_ram
// Frame bin store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spp_bin_ram (
   input  logic             clock,
   input  logic             wr_en,
   input  spp_pkg::bin_type wr_addr,
   input  spp_pkg::mag_type wr_data,
   input  spp_pkg::bin_type rd_addr,
   output spp_pkg::mag_type rd_data
);
   import spp_pkg::*;

   mag_type mem [NUM_BINS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hdl/spp_recip_div.sv
// ----------------------------------------------------------------------------
// spp_recip_div
// Restoring divider, one quotient bit per cycle: quotient = 2^26 / divisor.
// ----------------------------------------------------------------------------
module spp_recip_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  spp_pkg::mag_type               divisor,
   output logic                           done,
   output logic [spp_pkg::QUOT_W-1:0]     quotient
);
   import spp_pkg::*;

   logic [MAG_WIDTH-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic [DCNT_W-1:0]    cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   mag_type              div_ff, div_in;
   logic [MAG_WIDTH:0]   trial;

   // one shift-subtract step per cycle
   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      div_in  = div_ff;
      trial   = {rem_ff, quot_ff[QUOT_W-1]};
      if (start) begin
         rem_in  = '0;
         quot_in = {1'b1, {(QUOT_W-1){1'b0}}};
         cnt_in  = DCNT_W'(QUOT_W);
         busy_in = 1'b1;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in  = MAG_WIDTH'(trial - {1'b0, div_ff});
               quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
            end else begin
               rem_in  = trial[MAG_WIDTH-1:0];
               quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

endmodule

### hdl/spectral_peak_picker_agc.sv
// Bins are taken one per cycle while req_ready is high. After the last bin
// come peak selection, smoothing, the gain divide, the bin sort and the
// result words; each word is held until taken before the next is formed.
// One frame at a time: req_ready is low from the last bin until the final
// result word is taken. Reset (synchronous) restores the registers to
// 6/10/66, the smoothed peak to one LSB and empties the frame.
// ----------------------------------------------------------------------------
// spectral_peak_picker_agc
// Greedy spectral peak picker with minimum spacing and automatic gain.
// ----------------------------------------------------------------------------
module spectral_peak_picker_agc (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [spp_pkg::MAG_WIDTH-1:0] req_magnitude,
   input  logic                          req_last_bin,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [6:0]                    rsp_peak_bin,
   output logic [15:0]                   rsp_peak_level,
   output logic                          rsp_last_peak,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [15:0]                   csr_wdata
);
   import spp_pkg::*;

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_MUL1  = 4'd2;
   localparam logic [3:0] S_MUL2  = 4'd3;
   localparam logic [3:0] S_DIVS  = 4'd4;
   localparam logic [3:0] S_DIVW  = 4'd5;
   localparam logic [3:0] S_SORT  = 4'd6;
   localparam logic [3:0] S_OMUL  = 4'd7;
   localparam logic [3:0] S_OSEND = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [4:0]          npeaks_ff, npeaks_in;
   logic [6:0]          min_spacing_ff, min_spacing_in;
   logic [15:0]         alpha_ff, alpha_in;
   logic [CNT_W-1:0]    bin_cnt_ff, bin_cnt_in;
   logic [PK_CNT_W-1:0] pc_ff, pc_in;
   logic [PK_CNT_W-1:0] total_ff, total_in;
   bin_type             pk_bin_ff [MAX_PEAKS];
   bin_type             pk_bin_in [MAX_PEAKS];
   mag_type             pk_lvl_ff [MAX_PEAKS];
   mag_type             pk_lvl_in [MAX_PEAKS];
   logic [CNT_W-1:0]    scan_b_ff, scan_b_in;
   logic                eval_vld_ff, eval_vld_in;
   bin_type             eval_bin_ff, eval_bin_in;
   logic                found_ff, found_in;
   bin_type             best_bin_ff, best_bin_in;
   mag_type             best_mag_ff, best_mag_in;
   mag_type             sp_ff, sp_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [GAIN_W-1:0]   gain_ff, gain_in;
   logic [PK_CNT_W-1:0] pass_ff, pass_in;
   logic [PK_IDX_W-1:0] k_ff, k_in;
   logic                rsp_vld_ff, rsp_vld_in;
   bin_type             rsp_bin_ff, rsp_bin_in;
   logic [LEVEL_W-1:0]  rsp_lvl_ff, rsp_lvl_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                load_wr;
   logic                issue;
   logic                eligible;
   mag_type             rd_data;
   mag_type             strongest;
   logic [MAG_WIDTH-1:0] mul_a;
   logic [COEF_W-1:0]   mul_b;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W-1:0]   acc_sum;
   logic [PROD_W-12:0]  lvl_shift;
   logic                div_start;
   logic                div_done;
   logic [QUOT_W-1:0]   quot;
   logic [PK_CNT_W-1:0] pc_eff;
   logic                in_acc, out_acc;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_vld_ff && rsp_ready;
   assign load_wr = in_acc && !bin_cnt_ff[CNT_W-1];
   assign issue   = (state_ff == S_SCAN) && (scan_b_ff < bin_cnt_ff);

   spp_bin_ram u_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (bin_cnt_ff[BIN_W-1:0]),
      .wr_data (req_magnitude),
      .rd_addr (scan_b_ff[BIN_W-1:0]),
      .rd_data (rd_data)
   );

   spp_recip_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (sp_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // effective peak count, saturated to 1..MAX_PEAKS
   always_comb begin
      if (npeaks_ff == '0) begin
         pc_eff = PK_CNT_W'(1);
      end else if (PK_CNT_W'(npeaks_ff) > PK_CNT_W'(MAX_PEAKS)) begin
         pc_eff = PK_CNT_W'(MAX_PEAKS);
      end else begin
         pc_eff = PK_CNT_W'(npeaks_ff);
      end
   end

   // spacing check of the bin under evaluation against every pick so far
   always_comb begin
      logic [BIN_W-1:0] d;
      eligible = 1'b1;
      for (int k = 0; k < MAX_PEAKS; k++) begin
         d = (pk_bin_ff[k] > eval_bin_ff) ? pk_bin_ff[k] - eval_bin_ff
                                          : eval_bin_ff - pk_bin_ff[k];
         if (PK_CNT_W'(k) < total_ff) begin
            if ((pk_bin_ff[k] == eval_bin_ff) || (7'(d) < min_spacing_ff)) begin
               eligible = 1'b0;
            end
         end
      end
   end

   assign strongest = (total_ff != '0) ? pk_lvl_ff[0] : '0;

   // shared multiplier
   always_comb begin
      case (state_ff)
         S_MUL1: begin
            mul_a = sp_ff;
            mul_b = {1'b0, alpha_ff};
         end
         S_MUL2: begin
            mul_a = strongest;
            mul_b = COEF_W'(17'h10000 - {1'b0, alpha_ff});
         end
         default: begin
            mul_a = pk_lvl_ff[k_ff];
            mul_b = {1'b0, gain_ff};
         end
      endcase
   end

   assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign acc_sum   = acc_ff + prod + PROD_W'(32768);
   assign lvl_shift = prod[PROD_W-1:11];

   assign div_start = (state_ff == S_DIVS) && (sp_ff != '0);

   // sequencer and datapath
   always_comb begin
      state_in       = state_ff;
      npeaks_in      = npeaks_ff;
      min_spacing_in = min_spacing_ff;
      alpha_in       = alpha_ff;
      bin_cnt_in     = bin_cnt_ff;
      pc_in          = pc_ff;
      total_in       = total_ff;
      pk_bin_in      = pk_bin_ff;
      pk_lvl_in      = pk_lvl_ff;
      scan_b_in      = scan_b_ff;
      eval_vld_in    = 1'b0;
      eval_bin_in    = scan_b_ff[BIN_W-1:0];
      found_in       = found_ff;
      best_bin_in    = best_bin_ff;
      best_mag_in    = best_mag_ff;
      sp_in          = sp_ff;
      acc_in         = acc_ff;
      gain_in        = gain_ff;
      pass_in        = pass_ff;
      k_in           = k_ff;
      rsp_vld_in     = rsp_vld_ff;
      rsp_bin_in     = rsp_bin_ff;
      rsp_lvl_in     = rsp_lvl_ff;
      rsp_last_in    = rsp_last_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_NPEAKS:      npeaks_in      = csr_wdata[4:0];
            CSR_MIN_SPACING: min_spacing_in = csr_wdata[6:0];
            CSR_ALPHA:       alpha_in       = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_LOAD: begin
            if (in_acc) begin
               if (!bin_cnt_ff[CNT_W-1]) begin
                  bin_cnt_in = bin_cnt_ff + 1'b1;
               end
               if (req_last_bin) begin
                  pc_in     = pc_eff;
                  scan_b_in = CNT_W'(1);
                  found_in  = 1'b0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               scan_b_in   = scan_b_ff + 1'b1;
               eval_vld_in = 1'b1;
            end
            if (eval_vld_ff && eligible && (!found_ff || (rd_data > best_mag_ff))) begin
               found_in    = 1'b1;
               best_bin_in = eval_bin_ff;
               best_mag_in = rd_data;
            end
            // end of one pass over the store
            if (!issue && !eval_vld_ff) begin
               scan_b_in = CNT_W'(1);
               found_in  = 1'b0;
               if (found_ff) begin
                  pk_bin_in[total_ff[PK_IDX_W-1:0]] = best_bin_ff;
                  pk_lvl_in[total_ff[PK_IDX_W-1:0]] = best_mag_ff;
                  total_in = total_ff + 1'b1;
                  if ((total_ff + 1'b1) >= pc_ff) begin
                     state_in = S_MUL1;
                  end
               end else begin
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            if (strongest > sp_ff) begin
               sp_in    = strongest;
               state_in = S_DIVS;
            end else begin
               acc_in   = prod;
               state_in = S_MUL2;
            end
         end
         S_MUL2: begin
            sp_in    = acc_sum[MAG_WIDTH+15:16];
            state_in = S_DIVS;
         end
         S_DIVS: begin
            pass_in = '0;
            if (sp_ff == '0) begin
               gain_in  = GAIN_MAX;
               state_in = S_SORT;
            end else begin
               state_in = S_DIVW;
            end
         end
         S_DIVW: begin
            if (div_done) begin
               if (quot < QUOT_W'(GAIN_MIN)) begin
                  gain_in = GAIN_MIN;
               end else if (quot > QUOT_W'(GAIN_MAX)) begin
                  gain_in = GAIN_MAX;
               end else begin
                  gain_in = quot[GAIN_W-1:0];
               end
               state_in = S_SORT;
            end
         end
         S_SORT: begin
            // odd-even transposition pass; empty slots hold bin 0 and sort first
            for (int i = 0; i < MAX_PEAKS - 1; i++) begin
               if (((i % 2) == int'(pass_ff[0])) && (pk_bin_ff[i] > pk_bin_ff[i+1])) begin
                  pk_bin_in[i]   = pk_bin_ff[i+1];
                  pk_bin_in[i+1] = pk_bin_ff[i];
                  pk_lvl_in[i]   = pk_lvl_ff[i+1];
                  pk_lvl_in[i+1] = pk_lvl_ff[i];
               end
            end
            pass_in = pass_ff + 1'b1;
            if (pass_ff == PK_CNT_W'(MAX_PEAKS - 1)) begin
               k_in     = PK_IDX_W'(PK_CNT_W'(MAX_PEAKS) - pc_ff);
               state_in = S_OMUL;
            end
         end
         S_OMUL: begin
            rsp_bin_in  = pk_bin_ff[k_ff];
            rsp_lvl_in  = (lvl_shift > (PROD_W-11)'(LEVEL_ONE)) ? LEVEL_ONE
                                                                : lvl_shift[LEVEL_W-1:0];
            rsp_last_in = (k_ff == PK_IDX_W'(MAX_PEAKS - 1));
            rsp_vld_in  = 1'b1;
            state_in    = S_OSEND;
         end
         S_OSEND: begin
            if (out_acc) begin
               rsp_vld_in = 1'b0;
               if (rsp_last_ff) begin
                  // frame done: clear picks and counter
                  for (int i = 0; i < MAX_PEAKS; i++) begin
                     pk_bin_in[i] = '0;
                     pk_lvl_in[i] = '0;
                  end
                  total_in   = '0;
                  bin_cnt_in = '0;
                  state_in   = S_LOAD;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_OMUL;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_LOAD;
         npeaks_ff      <= 5'd6;
         min_spacing_ff <= 7'd10;
         alpha_ff       <= 16'd66;
         bin_cnt_ff     <= '0;
         total_ff       <= '0;
         sp_ff          <= MAG_WIDTH'(1);
         eval_vld_ff    <= 1'b0;
         found_ff       <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         for (int i = 0; i < MAX_PEAKS; i++) begin
            pk_bin_ff[i] <= '0;
            pk_lvl_ff[i] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         npeaks_ff      <= npeaks_in;
         min_spacing_ff <= min_spacing_in;
         alpha_ff       <= alpha_in;
         bin_cnt_ff     <= bin_cnt_in;
         total_ff       <= total_in;
         sp_ff          <= sp_in;
         eval_vld_ff    <= eval_vld_in;
         found_ff       <= found_in;
         rsp_vld_ff     <= rsp_vld_in;
         pk_bin_ff      <= pk_bin_in;
         pk_lvl_ff      <= pk_lvl_in;
      end
      pc_ff       <= pc_in;
      scan_b_ff   <= scan_b_in;
      eval_bin_ff <= eval_bin_in;
      best_bin_ff <= best_bin_in;
      best_mag_ff <= best_mag_in;
      acc_ff      <= acc_in;
      gain_ff     <= gain_in;
      pass_ff     <= pass_in;
      k_ff        <= k_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready      = (state_ff == S_LOAD);
   assign rsp_valid      = rsp_vld_ff;
   assign rsp_peak_bin   = rsp_bin_ff;
   assign rsp_peak_level = rsp_lvl_ff;
   assign rsp_last_peak  = rsp_last_ff;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives magnitude frames into the peak picker under random idling and
// back-pressure, predicts each frame's peak words and checks them in order.
// ----------------------------------------------------------------------------
module testbench;
   import spp_pkg::*;

   // index with no register behind it
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [MAG_WIDTH-1:0] req_magnitude = '0;
   logic                 req_last_bin = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [6:0]           rsp_peak_bin;
   logic [15:0]          rsp_peak_level;
   logic                 rsp_last_peak;
   logic                 csr_we = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [15:0]          csr_wdata = '0;

   typedef struct packed {
      logic [6:0]  bin;
      logic [15:0] level;
      logic        last;
   } peak_word_type;

   peak_word_type peak_queue[$];

   // predictor state
   logic [4:0]           cfg_count;
   logic [6:0]           cfg_spacing;
   logic [15:0]          cfg_alpha;
   logic [MAG_WIDTH-1:0] mag_mem[NUM_BINS];
   int unsigned          bin_fill;
   logic [MAG_WIDTH-1:0] smooth_level;

   int  error_count = 0;
   int  idle_count = 0;
   bit  rsp_idle_en = 1'b0;
   bit  req_idle_en = 1'b0;
   bit  rsp_hold = 1'b0;

   spectral_peak_picker_agc DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // frame closing: pick, smooth, gain, sort, emit
   task automatic predict_frame();
      int unsigned pc, total, k, j, b, best, empties, d;
      logic [MAG_WIDTH-1:0] bestmag, strongest;
      logic [6:0]  pbin[MAX_PEAKS];
      logic [MAG_WIDTH-1:0] plvl[MAX_PEAKS];
      bit taken[NUM_BINS];
      bit found, ok;
      logic [63:0] acc, g, lvl;
      logic [6:0] vb;
      logic [MAG_WIDTH-1:0] vl;
      peak_word_type w;
      pc = (cfg_count == 0) ? 1 : (cfg_count > MAX_PEAKS ? MAX_PEAKS : cfg_count);
      total = 0;
      foreach (taken[i]) taken[i] = 1'b0;
      while (total < pc) begin
         found = 1'b0; best = 0; bestmag = '0;
         for (b = 1; b < bin_fill; b++) begin
            ok = !taken[b];
            for (k = 0; k < total; k++) begin
               d = (pbin[k] > b) ? pbin[k] - b : b - pbin[k];
               if (d < cfg_spacing) ok = 1'b0;
            end
            if (ok && (!found || mag_mem[b] > bestmag)) begin
               found = 1'b1; best = b; bestmag = mag_mem[b];
            end
         end
         if (!found) break;
         taken[best] = 1'b1;
         pbin[total] = 7'(best);
         plvl[total] = bestmag;
         total++;
      end
      strongest = (total > 0) ? plvl[0] : '0;
      if (strongest > smooth_level) smooth_level = strongest;
      else begin
         acc = 64'(cfg_alpha) * smooth_level + 64'(65536 - cfg_alpha) * strongest + 32768;
         smooth_level = acc[16 +: MAG_WIDTH];
      end
      if (smooth_level == 0) g = 64'(GAIN_MAX);
      else begin
         g = (64'd1 << 26) / smooth_level;
         if (g < GAIN_MIN) g = 64'(GAIN_MIN);
         if (g > GAIN_MAX) g = 64'(GAIN_MAX);
      end
      for (k = 1; k < total; k++) begin
         vb = pbin[k]; vl = plvl[k]; j = k;
         while (j > 0 && pbin[j-1] > vb) begin
            pbin[j] = pbin[j-1]; plvl[j] = plvl[j-1]; j--;
         end
         pbin[j] = vb; plvl[j] = vl;
      end
      empties = pc - total;
      for (k = 0; k < pc; k++) begin
         w = '0;
         if (k >= empties) begin
            w.bin = pbin[k - empties];
            lvl = (64'(plvl[k - empties]) * g) >> 11;
            w.level = (lvl > LEVEL_ONE) ? LEVEL_ONE : lvl[15:0];
         end
         w.last = (k + 1 == pc);
         peak_queue.push_back(w);
      end
      bin_fill = 0;
   endtask

   // one bin word, held until accepted; valid drops only while idling
   task automatic send_bin(input logic [MAG_WIDTH-1:0] mag, input bit last);
      while (req_idle_en && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_magnitude <= mag;
      req_last_bin <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (bin_fill < NUM_BINS) begin
         mag_mem[bin_fill] = mag;
         bin_fill++;
      end
      if (last) predict_frame();
      @(negedge clock);
   endtask

   task automatic send_frame(input int unsigned len, input int mode);
      logic [MAG_WIDTH-1:0] m;
      for (int unsigned i = 0; i < len; i++) begin
         case (mode)
            0: m = MAG_WIDTH'($urandom);
            1: m = MAG_WIDTH'($urandom_range(3) << 22);
            2: m = (i % 2) ? 24'hFFFFFF : 24'h0;
            default: m = MAG_WIDTH'($urandom_range(255));
         endcase
         send_bin(m, i + 1 == len);
      end
   endtask

   // sender pauses until every expected word has come
   task automatic drain();
      req_valid <= 1'b0;
      while (peak_queue.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_NPEAKS:      cfg_count = val[4:0];
         CSR_MIN_SPACING: cfg_spacing = val[6:0];
         CSR_ALPHA:       cfg_alpha = val;
         default: ;
      endcase
   endtask

   task automatic test_reset_settings();
      send_frame(20, 0);
      send_frame(1, 0);   // DC only
      send_bin(24'hFFFFFF, 1'b0);
      send_bin(24'h000000, 1'b0);
      send_bin(24'h000000, 1'b1);  // ties, all zero but one
      drain();
   endtask

   task automatic test_extreme_config();
      write_csr(CSR_NPEAKS, 16'd0);
      write_csr(CSR_MIN_SPACING, 16'd0);
      write_csr(CSR_ALPHA, 16'hFFFF);
      write_csr(CSR_UNUSED, 16'hFFFF);
      send_frame(6, 2);
      drain();
      write_csr(CSR_NPEAKS, 16'd31);
      write_csr(CSR_MIN_SPACING, 16'd127);
      write_csr(CSR_ALPHA, 16'd0);
      send_frame(8, 0);
      drain();
      write_csr(CSR_NPEAKS, 16'd16);
      write_csr(CSR_MIN_SPACING, 16'd0);
      send_frame(5, 3);
      drain();
   endtask

   task automatic test_long_frame();
      write_csr(CSR_NPEAKS, 16'd4);
      write_csr(CSR_MIN_SPACING, 16'd3);
      send_frame(132, 1);   // past the store, extra bins dropped
      drain();
   endtask

   task automatic test_random();
      req_idle_en = 1'b1; rsp_idle_en = 1'b1;
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(CSR_NPEAKS, 16'($urandom_range(16)));
         write_csr(CSR_MIN_SPACING, 16'($urandom_range(6)));
         write_csr(CSR_ALPHA, 16'($urandom));
         for (int f = 0; f < 2; f++) send_frame($urandom_range(2, 6), $urandom_range(3));
         if (ph == 2) begin
            // hold the result side while the next frame arrives
            rsp_hold = 1'b1;
            send_frame(6, 0);
            send_frame(4, 0);
         end
         if (ph == 3) begin
            req_idle_en = 1'b0; rsp_idle_en = 1'b0;
            send_frame(10, 0);
            req_idle_en = 1'b1; rsp_idle_en = 1'b1;
         end
         drain();
      end
   endtask

   // result side idling and long hold-off
   always @(negedge clock) begin
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
         repeat (300) @(negedge clock);
         rsp_hold = 1'b0;
      end else
         rsp_ready <= !(rsp_idle_en && $urandom_range(99) < 18);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (peak_queue.size() == 0) begin
            $display("%0t unexpected word bin %0d level %0d", $time,
                     rsp_peak_bin, rsp_peak_level);
            error_count++;
         end else begin
            peak_word_type e;
            e = peak_queue.pop_front();
            if (e.bin !== rsp_peak_bin) begin
               $display("%0t bin exp %0d got %0d", $time, e.bin, rsp_peak_bin);
               error_count++;
            end
            if (e.level !== rsp_peak_level) begin
               $display("%0t level exp %0d got %0d", $time, e.level, rsp_peak_level);
               error_count++;
            end
            if (e.last !== rsp_last_peak) begin
               $display("%0t last exp %0d got %0d", $time, e.last, rsp_last_peak);
               error_count++;
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_count <= 0;
      else if (idle_count >= 20000) begin
         $display("testbench: errors");
         $finish;
      end else
         idle_count <= idle_count + 1;
   end

   initial begin
      cfg_count = 6; cfg_spacing = 10; cfg_alpha = 66;
      bin_fill = 0; smooth_level = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_extreme_config();
      test_long_frame();
      test_random();
      if (error_count == 0 && peak_queue.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end
endmodule
